/* sv/ole_pkg.sv */
package ole_pkg;

  // List geometry
  localparam int CAPACITY = 32;
  localparam int DATA_W   = 32;
  localparam int FUNC_W   = 4;
  localparam int INDEX_W  = 6;
  localparam int LEN_W    = 6;
  localparam int POS_W    = 5;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int STAT_W   = 2;

  localparam logic [DATA_W-1:0] ERR_VALUE = {DATA_W{1'b1}};

  // Request codes
  typedef enum logic [FUNC_W-1:0] {
    FN_ADD_BACK     = 4'd0,
    FN_ADD_FRONT    = 4'd1,
    FN_INSERT_AT    = 4'd2,
    FN_REMOVE_BACK  = 4'd3,
    FN_REMOVE_FRONT = 4'd4,
    FN_REMOVE_AT    = 4'd5,
    FN_MEMBER       = 4'd6,
    FN_GET          = 4'd7,
    FN_FIND         = 4'd8,
    FN_LENGTH       = 4'd9,
    FN_CLEAR        = 4'd10
  } func_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_RANGE = 2'd2,
    STS_FULL  = 2'd3
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
    logic srch;
    logic emit;
  } ole_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_search;
    logic out_free;
  } ole_stat_t;

endpackage

/* sv/ordered_list_engine_core.sv */
// Channel  Handshake            Payload
// in       in_valid / in_stall  func, value, index
// out      out_valid / out_stall result_value, position, found, status, length
//
// A request is taken in idle, applied to the list in execute and its result
// loaded into the output register in emit, waiting while a result is stalled.
// Member and find add a search state: matches are registered before encoding.
// The per-slot shift network updates all 32 entries in the execute cycle.
// Reset (rst, synchronous) empties the list; entry contents are not cleared.
// A new request is taken while a finished result waits under out_stall.
module ordered_list_engine_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ole_pkg::FUNC_W-1:0]          func,
  input  logic signed [ole_pkg::DATA_W-1:0]   value,
  input  logic [ole_pkg::INDEX_W-1:0]         index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ole_pkg::DATA_W-1:0]   result_value,
  output logic [ole_pkg::POS_W-1:0]           position,
  output logic                                found,
  output logic [ole_pkg::STAT_W-1:0]          status,
  output logic [ole_pkg::LEN_W-1:0]           length
);
  import ole_pkg::*;

  ole_cmd_t  cmd;
  ole_stat_t dp_stat;

  ole_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .dp_stat  (dp_stat),
    .cmd      (cmd)
  );

  ole_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .dp_stat      (dp_stat),
    .func         (func),
    .value        (value),
    .index        (index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .position     (position),
    .found        (found),
    .status       (status),
    .length       (length)
  );

  // Leave idle right after a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken but controller stayed idle");

  // A full status only happens on a full list
  a_full_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STS_FULL) |-> (length == LEN_W'(CAPACITY)))
    else $error("full status with list not at capacity");

  // A search hit always reports success
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (status == STS_OK))
    else $error("found flag with error status");

  // The list never grows past capacity
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (length <= LEN_W'(CAPACITY)))
    else $error("length beyond capacity");

endmodule

/* sv/ole_ctrl.sv */
module ole_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ole_pkg::ole_stat_t dp_stat,
  output ole_pkg::ole_cmd_t  cmd
);
  import ole_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SRCH = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = dp_stat.is_search ? S_SRCH : S_EMIT;
      end
      S_SRCH: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (dp_stat.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Drive commands
  assign in_stall = (state != S_IDLE);
  assign cmd.load = (state == S_IDLE) && in_valid;
  assign cmd.exec = (state == S_EXEC);
  assign cmd.srch = (state == S_SRCH);
  assign cmd.emit = (state == S_EMIT) && dp_stat.out_free;

endmodule

/* sv/ole_dpath.sv */
module ole_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  ole_pkg::ole_cmd_t                   cmd,
  output ole_pkg::ole_stat_t                  dp_stat,
  input  logic [ole_pkg::FUNC_W-1:0]          func,
  input  logic signed [ole_pkg::DATA_W-1:0]   value,
  input  logic [ole_pkg::INDEX_W-1:0]         index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ole_pkg::DATA_W-1:0]   result_value,
  output logic [ole_pkg::POS_W-1:0]           position,
  output logic                                found,
  output logic [ole_pkg::STAT_W-1:0]          status,
  output logic [ole_pkg::LEN_W-1:0]           length
);
  import ole_pkg::*;

  // Held request
  logic [FUNC_W-1:0]  req_func;
  logic [DATA_W-1:0]  req_value;
  logic [INDEX_W-1:0] req_index;

  // List storage
  logic [DATA_W-1:0]  entries [CAPACITY];
  logic [LEN_W-1:0]   count;
  logic [CAPACITY-1:0] hit_vec;

  // Pending result
  logic [DATA_W-1:0]  res_value;
  logic [POS_W-1:0]   res_pos;
  logic               res_found;
  status_t            res_status;
  logic [LEN_W-1:0]   res_length;

  // Execute-step decode
  logic               ins_en;
  logic               rem_en;
  logic [LEN_W-1:0]   ins_pos;
  logic [LEN_W-1:0]   rem_pos;
  logic [LEN_W-1:0]   count_next;
  logic [IDX_W-1:0]   rd_idx;
  logic [DATA_W-1:0]  rd_data;
  logic [DATA_W-1:0]  ex_value;
  status_t            ex_status;

  // Search encode
  logic [IDX_W-1:0]   enc_pos;
  logic               enc_hit;

  logic               out_free;

  assign out_free          = !out_valid || !out_stall;
  assign dp_stat.out_free  = out_free;
  assign dp_stat.is_search = (req_func == FN_MEMBER) || (req_func == FN_FIND);

  // Capture request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_func  <= func;
      req_value <= value;
      req_index <= index;
    end
  end

  // Single read port into the list
  assign rd_data = entries[rd_idx];

  // Decode the request against the current count
  always_comb begin
    ins_en     = 1'b0;
    rem_en     = 1'b0;
    ins_pos    = count;
    rem_pos    = count - LEN_W'(1);
    count_next = count;
    rd_idx     = req_index[IDX_W-1:0];
    ex_value   = '0;
    ex_status  = STS_OK;
    case (req_func)
      FN_ADD_BACK, FN_ADD_FRONT, FN_INSERT_AT: begin
        if (req_func == FN_ADD_FRONT) begin
          ins_pos = '0;
        end else if (req_func == FN_INSERT_AT) begin
          ins_pos = req_index;
        end
        if (req_func == FN_INSERT_AT && req_index > count) begin
          ex_status = STS_RANGE;
        end else if (count >= LEN_W'(CAPACITY)) begin
          ex_status = STS_FULL;
        end else begin
          ins_en     = 1'b1;
          count_next = count + LEN_W'(1);
        end
      end
      FN_REMOVE_BACK, FN_REMOVE_FRONT, FN_REMOVE_AT: begin
        if (req_func == FN_REMOVE_FRONT) begin
          rem_pos = '0;
        end else if (req_func == FN_REMOVE_AT) begin
          rem_pos = req_index;
        end
        rd_idx = rem_pos[IDX_W-1:0];
        if (count == '0) begin
          ex_status = STS_EMPTY;
        end else if (req_func == FN_REMOVE_AT && req_index >= count) begin
          ex_status = STS_RANGE;
        end else begin
          rem_en     = 1'b1;
          count_next = count - LEN_W'(1);
          ex_value   = rd_data;
        end
      end
      FN_GET: begin
        if (req_index >= count) begin
          ex_status = STS_RANGE;
        end else begin
          ex_value = rd_data;
        end
      end
      FN_LENGTH: begin
        ex_value = DATA_W'(count);
      end
      FN_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
    if (ex_status != STS_OK) ex_value = ERR_VALUE;
  end

  // Shift entries open for an insert or closed after a remove
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_entry
    localparam int PREV = (gi == 0) ? 0 : gi - 1;
    localparam int NEXT = (gi == CAPACITY - 1) ? gi : gi + 1;
    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        if (ins_en) begin
          if (LEN_W'(gi) == ins_pos) begin
            entries[gi] <= req_value;
          end else if (LEN_W'(gi) > ins_pos) begin
            entries[gi] <= entries[PREV];
          end
        end else if (rem_en && LEN_W'(gi) >= rem_pos && gi < CAPACITY - 1) begin
          entries[gi] <= entries[NEXT];
        end
      end
    end
  end

  // Compare every live entry against the search value
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        hit_vec[i] <= (entries[i] == req_value) && (LEN_W'(i) < count);
      end
    end
  end

  // Pick the lowest matching slot
  always_comb begin
    enc_pos = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hit_vec[i]) enc_pos = IDX_W'(i);
    end
  end
  assign enc_hit = |hit_vec;

  // Count register
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  // Build the pending result
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_value  <= ex_value;
      res_pos    <= '0;
      res_found  <= 1'b0;
      res_status <= ex_status;
      res_length <= count_next;
    end else if (cmd.srch) begin
      res_pos    <= enc_hit ? POS_W'(enc_pos) : '0;
      res_found  <= enc_hit;
      res_status <= STS_OK;
      res_length <= count;
      if (req_func == FN_FIND) begin
        res_value <= enc_hit ? DATA_W'(enc_pos) : ERR_VALUE;
      end else begin
        res_value <= '0;
      end
    end
  end

  // Output register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result_value <= res_value;
      position     <= res_pos;
      found        <= res_found;
      status       <= res_status;
      length       <= res_length;
    end
  end

endmodule
